[rtl/utc_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 converter.
`default_nettype none

package utc_pkg;

   // Default width of the running byte counter.
   localparam int COUNT_BITS_DEF = 16;
   // Default number of entries in the queue between the front and back parts.
   localparam int QUEUE_DEPTH_DEF = 2;

   // Reset value of the output capacity register.
   localparam logic [15:0] CAP_RESET = 16'd1024;

   // Surrogate ranges.
   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

   // Code point limits for the one, two and three byte encodings.
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   // Offset of the high-surrogate payload that forms a supplementary plane.
   localparam logic [10:0] PLANE_OFFSET = 11'd64;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ILLEGAL = 2'd1,
      ST_TOO_BIG = 2'd2
   } status_type;

   // One classified request, ready to be sent out byte by byte.
   typedef struct packed {
      logic [3:0][7:0] bytes;      // bytes[0] goes out first
      logic [1:0]      last_idx;   // index of the final byte
      logic            done_final; // string_done on the final byte
      status_type      status;
      logic [15:0]     used0;      // bytes_used on the first byte
   } job_type;

endpackage

`default_nettype wire

[rtl/utc_front.sv]
// Front part: accepts requests, tracks string state and encodes each code point.
`default_nettype none

module utc_front import utc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last_unit,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_out_capacity,
   input  wire logic        queue_full,
   output logic             push,
   output job_type          push_job
);

   // Compare width: wide enough for the count, the capacity and a carry.
   localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
   localparam logic [CW-1:0] COUNT_MAX = CW'({COUNT_BITS{1'b1}});

   logic [15:0]           capacity_ff;
   logic [9:0]            pending_high_ff, pending_high_in;
   logic                  pending_valid_ff, pending_valid_in;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;
   logic                  discarding_ff, discarding_in;

   logic          accept;
   logic [CW-1:0] count_ext;
   logic [CW-1:0] cap_ext;
   logic [CW-1:0] cap_eff;
   logic [CW-1:0] count_plus_n;
   logic [CW-1:0] count_plus_one;
   logic          is_high;
   logic          is_low;
   logic [10:0]   plane;
   logic [20:0]   cp4;
   logic [2:0]    nbytes;
   logic [3:0][7:0] enc;
   logic          fail;
   status_type    fail_status;
   logic          emit_ok;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_out_capacity;
      end
   end

   // Classification of the unit and encoding of its code point.
   assign is_high = (req_code_unit >= HIGH_SURR_FIRST) && (req_code_unit <= HIGH_SURR_LAST);
   assign is_low  = (req_code_unit >= LOW_SURR_FIRST) && (req_code_unit <= LOW_SURR_LAST);
   assign plane   = {1'b0, pending_high_ff} + PLANE_OFFSET;
   assign cp4     = {plane[10:0], req_code_unit[9:0]};

   always_comb begin
      enc    = '0;
      nbytes = 3'd1;
      if (pending_valid_ff) begin
         nbytes = 3'd4;
         enc[0] = LEAD_FOUR | {5'd0, cp4[20:18]};
         enc[1] = CONT_MARK | {2'd0, cp4[17:12]};
         enc[2] = CONT_MARK | {2'd0, cp4[11:6]};
         enc[3] = CONT_MARK | {2'd0, cp4[5:0]};
      end else if (req_code_unit < ONE_BYTE_LIMIT) begin
         nbytes = 3'd1;
         enc[0] = req_code_unit[7:0];
      end else if (req_code_unit < TWO_BYTE_LIMIT) begin
         nbytes = 3'd2;
         enc[0] = LEAD_TWO | {3'd0, req_code_unit[10:6]};
         enc[1] = CONT_MARK | {2'd0, req_code_unit[5:0]};
      end else begin
         nbytes = 3'd3;
         enc[0] = LEAD_THREE | {4'd0, req_code_unit[15:12]};
         enc[1] = CONT_MARK | {2'd0, req_code_unit[11:6]};
         enc[2] = CONT_MARK | {2'd0, req_code_unit[5:0]};
      end
   end

   // Capacity arithmetic; the capacity in effect never exceeds the counter range.
   assign count_ext      = CW'(byte_count_ff);
   assign cap_ext        = CW'(capacity_ff);
   assign cap_eff        = (cap_ext > COUNT_MAX) ? COUNT_MAX : cap_ext;
   assign count_plus_n   = count_ext + CW'(nbytes);
   assign count_plus_one = count_ext + CW'(1);

   // Decision for the accepted request and next string state.
   always_comb begin
      fail             = 1'b0;
      fail_status      = ST_OK;
      emit_ok          = 1'b0;
      pending_high_in  = pending_high_ff;
      pending_valid_in = pending_valid_ff;
      byte_count_in    = byte_count_ff;
      discarding_in    = discarding_ff;

      if (accept) begin
         if (discarding_ff) begin
            if (req_last_unit) begin
               discarding_in = 1'b0;
               byte_count_in = '0;
            end
         end else begin
            if (pending_valid_ff) begin
               if (!is_low) begin
                  fail        = 1'b1;
                  fail_status = ST_ILLEGAL;
               end else if (count_plus_n > cap_eff) begin
                  fail        = 1'b1;
                  fail_status = ST_TOO_BIG;
               end else begin
                  emit_ok = 1'b1;
               end
            end else if (count_ext >= cap_eff) begin
               fail        = 1'b1;
               fail_status = ST_TOO_BIG;
            end else if (is_high) begin
               if (req_last_unit) begin
                  fail        = 1'b1;
                  fail_status = ST_ILLEGAL;
               end else begin
                  pending_high_in  = req_code_unit[9:0];
                  pending_valid_in = 1'b1;
               end
            end else if (is_low) begin
               fail        = 1'b1;
               fail_status = ST_ILLEGAL;
            end else if (count_plus_n > cap_eff) begin
               fail        = 1'b1;
               fail_status = ST_TOO_BIG;
            end else begin
               emit_ok = 1'b1;
            end

            // A consumed pair, an error or a finished string drops the held unit.
            if (fail || emit_ok) begin
               pending_high_in  = '0;
               pending_valid_in = 1'b0;
            end
            if (emit_ok) begin
               byte_count_in = count_plus_n[COUNT_BITS-1:0];
            end
            if (fail && !req_last_unit) begin
               discarding_in = 1'b1;
            end
            if ((fail || emit_ok) && req_last_unit) begin
               byte_count_in = '0;
               discarding_in = 1'b0;
            end
         end
      end
   end

   // String state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_high_ff  <= '0;
         pending_valid_ff <= 1'b0;
         byte_count_ff    <= '0;
         discarding_ff    <= 1'b0;
      end else begin
         pending_high_ff  <= pending_high_in;
         pending_valid_ff <= pending_valid_in;
         byte_count_ff    <= byte_count_in;
         discarding_ff    <= discarding_in;
      end
   end

   // Job handed to the queue.
   assign push = fail || emit_ok;

   always_comb begin
      push_job = '0;
      if (fail) begin
         push_job.bytes      = '0;
         push_job.last_idx   = 2'd0;
         push_job.done_final = 1'b1;
         push_job.status     = fail_status;
         push_job.used0      = count_ext[15:0];
      end else begin
         push_job.bytes      = enc;
         push_job.last_idx   = 2'(nbytes - 3'd1);
         push_job.done_final = req_last_unit;
         push_job.status     = ST_OK;
         push_job.used0      = count_plus_one[15:0];
      end
   end

   // A held high surrogate and the discard mode exclude each other.
   assert property (@(posedge clock) disable iff (reset)
      !(pending_valid_ff && discarding_ff))
      else $error("utc_front: held surrogate while discarding");

   // The last unit of a string always leaves a clean state behind.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_last_unit |=>
         !pending_valid_ff && !discarding_ff && (byte_count_ff == '0))
      else $error("utc_front: state not cleared after last unit");

endmodule

`default_nettype wire

[rtl/utc_queue.sv]
// Short job queue between the front and back parts.
`default_nettype none

module utc_queue import utc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);

   job_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The front never offers a job to a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("utc_queue: push into full queue");

   // The fill count stays within the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("utc_queue: fill count out of range");

endmodule

`default_nettype wire

[rtl/utc_back.sv]
// Back part: sends each queued job one UTF-8 byte per cycle while not stalled.
`default_nettype none

module utc_back import utc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_run_last,
   output logic         rsp_string_done,
   output logic [1:0]   rsp_status,
   output logic [15:0]  rsp_bytes_used
);

   job_type     cur_ff, cur_in;
   logic [1:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        run_last_ff;
   logic        string_done_ff;
   status_type  status_ff;
   logic [15:0] bytes_used_ff;

   job_type    src;
   logic [1:0] idx;
   logic       src_valid;
   logic       advance;
   logic       fire;
   logic       is_final;

   // Source is the job in progress, else the queue head, so jobs follow without a gap.
   assign src       = busy_ff ? cur_ff : head_job;
   assign idx       = busy_ff ? idx_ff : 2'd0;
   assign src_valid = busy_ff || head_valid;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = advance && src_valid;
   assign is_final  = (idx == src.last_idx);
   assign pop       = fire && !busy_ff;

   // Sequencer over the bytes of one job.
   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire;
      end
      if (fire) begin
         cur_in  = src;
         idx_in  = idx + 2'd1;
         busy_in = !is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register and job copy; payload only.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (fire) begin
         out_byte_ff    <= src.bytes[idx];
         run_last_ff    <= is_final;
         string_done_ff <= is_final && src.done_final;
         status_ff      <= src.status;
         bytes_used_ff  <= src.used0 + 16'(idx);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_done = string_done_ff;
   assign rsp_status      = status_ff;
   assign rsp_bytes_used  = bytes_used_ff;

   // An error result is a single zero byte that ends the string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_OK) |->
         run_last_ff && string_done_ff && (out_byte_ff == 8'd0))
      else $error("utc_back: malformed error result");

endmodule

`default_nettype wire

[rtl/utf16_to_utf8_converter_core.sv]
// Top level of the UTF-16 to UTF-8 converter: front, job queue and back.
//
// Takes one UTF-16 code unit per request and returns the UTF-8 encoding one byte per
// result. A request is accepted whenever the job queue has room; the result port
// delivers one byte per cycle unless the receiver stalls, and a request yields 1 to 4
// bytes (a BMP character up to 3), while a held high surrogate or a discarded unit
// gives no result. Errors give a single status result with a zero byte; later units
// up to the one marked last are dropped. The capacity register may be written only
// while the block is idle.
`default_nettype none

module utf16_to_utf8_converter_core import utc_pkg::*; #(
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_code_unit,
   input  wire logic        req_last_unit,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_string_done,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_bytes_used,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_out_capacity
);

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // Front part: classification and encoding.
   utc_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_unit   (req_code_unit),
      .req_last_unit   (req_last_unit),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_out_capacity(csr_out_capacity),
      .queue_full      (queue_full),
      .push            (push),
      .push_job        (push_job)
   );

   // Job queue between the two parts.
   utc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   // Back part: byte serializer and result register.
   utc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_done(rsp_string_done),
      .rsp_status     (rsp_status),
      .rsp_bytes_used (rsp_bytes_used)
   );

endmodule

`default_nettype wire

[sim/tb_utf16_to_utf8_converter_core.sv]
// Self-checking testbench for the UTF-16 to UTF-8 converter core with a predicting scoreboard.
module tb_utf16_to_utf8_converter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import utc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int SUPP_BASE    = 'h10000;
   localparam int COUNT_MAX    = (1 << COUNT_BITS_DEF) - 1;

   // Receiver stall patterns.
   typedef enum int {
      RX_FREE,
      RX_ALTERNATE,
      RX_RANDOM,
      RX_SHORT_BURST,
      RX_LONG_BURST
   } rx_mode_type;

   // One UTF-8 byte as seen on the result port.
   typedef struct {
      logic [7:0]  out_byte;
      logic        run_last;
      logic        string_done;
      status_type  status;
      logic [15:0] bytes_used;
   } utf8_result_type;

   // Predicts the UTF-8 bytes of each request and checks the returned bytes in order.
   class utf8_scoreboard;
      int              capacity    = CAP_RESET;
      logic [9:0]      held_high   = '0;
      logic            held_valid  = 1'b0;
      int              byte_count  = 0;
      logic            discarding  = 1'b0;
      int              mismatches  = 0;
      utf8_result_type expected_bytes[$];

      function void clear_string();
         held_high  = '0;
         held_valid = 1'b0;
         byte_count = 0;
         discarding = 1'b0;
      endfunction

      function void set_capacity(logic [15:0] value);
         capacity = value;
      endfunction

      function void push_result(logic [7:0] b, logic rl, logic sd, status_type st,
                                logic [15:0] used);
         utf8_result_type r;
         r.out_byte    = b;
         r.run_last    = rl;
         r.string_done = sd;
         r.status      = st;
         r.bytes_used  = used;
         expected_bytes.push_back(r);
      endfunction

      // An error gives one status byte and drops units up to the end of the string.
      function void report_error(status_type code, logic last);
         push_result(8'h00, 1'b1, 1'b1, code, 16'(byte_count));
         if (last) begin
            clear_string();
         end else begin
            held_high  = '0;
            held_valid = 1'b0;
            discarding = 1'b1;
         end
      endfunction

      function void note_request(logic [15:0] unit, logic last);
         int         cp;
         int         n;
         int         limit;
         logic [7:0] enc [4];
         limit = (capacity < COUNT_MAX) ? capacity : COUNT_MAX;

         // Units after an error are dropped until the string ends.
         if (discarding) begin
            if (last) clear_string();
            return;
         end

         // Decode the code point, pairing surrogates.
         if (held_valid) begin
            if (unit < LOW_SURR_FIRST || unit > LOW_SURR_LAST) begin
               report_error(ST_ILLEGAL, last);
               return;
            end
            cp = SUPP_BASE + (int'(held_high) << 10) + int'(unit - LOW_SURR_FIRST);
            held_high  = '0;
            held_valid = 1'b0;
         end else begin
            if (byte_count >= limit) begin
               report_error(ST_TOO_BIG, last);
               return;
            end
            if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
               if (last) begin
                  report_error(ST_ILLEGAL, last);
                  return;
               end
               held_high  = 10'(unit - HIGH_SURR_FIRST);
               held_valid = 1'b1;
               return;
            end
            if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST) begin
               report_error(ST_ILLEGAL, last);
               return;
            end
            cp = unit;
         end

         // Encode as one to four UTF-8 bytes.
         if (cp < ONE_BYTE_LIMIT) begin
            enc[0] = 8'(cp);
            n = 1;
         end else if (cp < TWO_BYTE_LIMIT) begin
            enc[0] = LEAD_TWO | 8'(cp >> 6);
            enc[1] = CONT_MARK | 8'(cp & 'h3F);
            n = 2;
         end else if (cp < SUPP_BASE) begin
            enc[0] = LEAD_THREE | 8'(cp >> 12);
            enc[1] = CONT_MARK | 8'((cp >> 6) & 'h3F);
            enc[2] = CONT_MARK | 8'(cp & 'h3F);
            n = 3;
         end else begin
            enc[0] = LEAD_FOUR | 8'(cp >> 18);
            enc[1] = CONT_MARK | 8'((cp >> 12) & 'h3F);
            enc[2] = CONT_MARK | 8'((cp >> 6) & 'h3F);
            enc[3] = CONT_MARK | 8'(cp & 'h3F);
            n = 4;
         end

         // The whole sequence must fit, or none of it is sent.
         if (byte_count + n > limit) begin
            report_error(ST_TOO_BIG, last);
            return;
         end
         for (int k = 0; k < n; k++) begin
            byte_count = byte_count + 1;
            push_result(enc[k], k == n - 1, (k == n - 1) && last, ST_OK, 16'(byte_count));
         end
         if (last) clear_string();
      endfunction

      function void check_response(utf8_result_type got);
         utf8_result_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: unexpected result byte %h run_last %b done %b status %0d used %0d",
                        got.out_byte, got.run_last, got.string_done, got.status,
                        got.bytes_used);
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
             got.string_done !== want.string_done || got.status !== want.status ||
             got.bytes_used !== want.bytes_used) begin
            mismatches++;
            // Fields in order: byte, run_last, string_done, status, bytes_used.
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: expected %h/%b/%b/%0d/%0d got %h/%b/%b/%0d/%0d",
                        want.out_byte, want.run_last, want.string_done, want.status,
                        want.bytes_used, got.out_byte, got.run_last, got.string_done,
                        got.status, got.bytes_used);
         end
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [15:0] req_code_unit    = '0;
   logic        req_last_unit    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_done;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_bytes_used;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_out_capacity = CAP_RESET;

   utf8_scoreboard sb = new;
   int          cycle_count = 0;
   int          burst_left  = 0;
   int          units_sent  = 0;
   bit          quiet       = 1'b0;
   int          rx_tick     = 0;
   rx_mode_type rx_mode     = RX_FREE;

   utf16_to_utf8_converter_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_code_unit    (req_code_unit),
      .req_last_unit    (req_last_unit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_string_done  (rsp_string_done),
      .rsp_status       (rsp_status),
      .rsp_bytes_used   (rsp_bytes_used),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_out_capacity (csr_out_capacity)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf16_to_utf8_converter_core regression: fail");
         $finish;
      end
   end

   // Note each accepted request first, then check each accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_code_unit, req_last_unit);
         if (rsp_valid && !rsp_stall)
            sb.check_response('{rsp_out_byte, rsp_run_last, rsp_string_done,
                                status_type'(rsp_status), rsp_bytes_used});
      end
   end

   // The receiver stalls on a pattern that changes whenever the low six bits of rx_tick are zero.
   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_tick[5:0] == 6'd0) rx_mode <= rx_mode_type'($urandom_range(0, 4));
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALTERNATE:   rsp_stall <= rx_tick[0];
            RX_RANDOM:      rsp_stall <= ($urandom_range(0, 2) == 0);
            RX_SHORT_BURST: rsp_stall <= (rx_tick[4:2] == 3'd0);
            RX_LONG_BURST:  rsp_stall <= rx_tick[4];
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Send one code unit, with a random gap before each burst.
   task automatic send_unit(input logic [15:0] unit, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = quiet ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_code_unit <= unit;
      req_last_unit <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      units_sent++;
   endtask

   // Stop sending until every predicted byte has come back and the block is quiet.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.expected_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_out_capacity <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_capacity(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A BMP code unit of one, two or three UTF-8 bytes, never a surrogate.
   function automatic logic [15:0] pick_bmp(input int kind);
      logic [15:0] v;
      case (kind)
         0: v = 16'($urandom_range(0, 127));
         1: v = 16'($urandom_range(128, 2047));
         default: begin
            v = 16'($urandom_range(2048, 63487));
            if (v >= HIGH_SURR_FIRST) v = v + 16'h0800;
         end
      endcase
      return v;
   endfunction

   // A well-formed string of one to eight characters.
   task automatic send_clean_string();
      int nchars;
      int kind;
      nchars = $urandom_range(1, 8);
      for (int i = 0; i < nchars; i++) begin
         kind = $urandom_range(0, 3);
         if (kind == 3) begin
            send_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)), 1'b0);
            send_unit(LOW_SURR_FIRST + 16'($urandom_range(0, 1023)), i == nchars - 1);
         end else begin
            send_unit(pick_bmp(kind), i == nchars - 1);
         end
      end
   endtask

   // Noise and broken surrogate sequences.
   task automatic send_broken_item();
      case ($urandom_range(0, 3))
         0: send_unit(16'($urandom), 1'($urandom));
         1: send_unit(LOW_SURR_FIRST + 16'($urandom_range(0, 1023)), 1'($urandom));
         2: begin
            send_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)), 1'b0);
            if ($urandom_range(0, 1) == 0)
               send_unit(pick_bmp($urandom_range(0, 2)), 1'($urandom));
            else
               send_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)), 1'($urandom));
         end
         default: send_unit(HIGH_SURR_FIRST + 16'($urandom_range(0, 1023)), 1'b1);
      endcase
   endtask

   // One capacity setting with a run of random strings, closed by a last unit.
   task automatic run_phase(input logic [15:0] cap, input int items, input bit calm);
      int stop;
      wait_idle();
      write_capacity(cap);
      quiet = calm;
      stop  = units_sent + items;
      while (units_sent < stop) begin
         if ($urandom_range(0, 4) == 0) send_broken_item();
         else send_clean_string();
      end
      send_unit(pick_bmp(0), 1'b1);
      quiet = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Encoding boundaries under the reset capacity.
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      // Lowest and highest supplementary code points.
      send_unit(HIGH_SURR_FIRST, 1'b0);
      send_unit(LOW_SURR_FIRST, 1'b0);
      send_unit(HIGH_SURR_LAST, 1'b0);
      send_unit(LOW_SURR_LAST, 1'b1);
      // Lone low surrogate, then units dropped up to the last one.
      send_unit(LOW_SURR_FIRST, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(HIGH_SURR_FIRST, 1'b1);
      // Held high surrogate followed by a unit that is not a low surrogate.
      send_unit(HIGH_SURR_FIRST, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0042, 1'b1);
      // High surrogate marked last.
      send_unit(HIGH_SURR_LAST, 1'b1);

      // Zero capacity: the buffer is full before the first unit.
      wait_idle();
      write_capacity(16'd0);
      send_unit(16'h0041, 1'b1);
      // A three-byte sequence that does not fit after one byte.
      wait_idle();
      write_capacity(16'd3);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'h005A, 1'b1);
      // A surrogate pair that does not fit, and then one that fits exactly.
      wait_idle();
      write_capacity(16'd4);
      send_unit(16'h0041, 1'b0);
      send_unit(HIGH_SURR_FIRST, 1'b0);
      send_unit(LOW_SURR_FIRST, 1'b1);
      send_unit(HIGH_SURR_LAST, 1'b0);
      send_unit(LOW_SURR_LAST, 1'b1);

      // Random strings under several capacities.
      run_phase(16'hFFFF, 60, 1'b0);
      run_phase(16'd0, 12, 1'b0);
      run_phase(16'($urandom_range(1, 40)), 60, 1'b0);
      run_phase(CAP_RESET, 60, 1'b1);
      run_phase(16'($urandom), 60, 1'b0);
      run_phase(16'($urandom_range(4, 24)), 55, 1'b0);

      wait_idle();
      if (sb.mismatches == 0) begin
         $display("utf16_to_utf8_converter_core regression: pass");
      end else begin
         $display("utf16_to_utf8_converter_core regression: fail");
      end
      $finish;
   end

endmodule

[utf16_to_utf8_converter_core.f]
rtl/utc_pkg.sv
rtl/utc_front.sv
rtl/utc_queue.sv
rtl/utc_back.sv
rtl/utf16_to_utf8_converter_core.sv
sim/tb_utf16_to_utf8_converter_core.sv
